// File: rtl/sseq_pkg.sv
// shared types and constants for the stable sorted event queue
package sseq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int PID_W       = 8;
    localparam int TRANS_W     = 3;
    localparam int OCC_W       = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  ev_time;
        logic [PID_W-1:0]   pid;
        logic [TRANS_W-1:0] trans;
    } event_t;

    typedef struct packed {
        logic   ins;
        logic   pop;
        event_t item;
    } cell_ctl_t;

endpackage

// File: rtl/sseq_cell.sv
// one slot of the sorted chain: keeps, loads, or takes a neighbor's event
module sseq_cell (
    input  logic               clk,
    input  sseq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_le,
    input  sseq_pkg::event_t   left_data,
    input  sseq_pkg::event_t   right_data,
    output logic               le,
    output sseq_pkg::event_t   slot,
    output sseq_pkg::event_t   slot_next
);
    import sseq_pkg::*;

    event_t slot_reg;

    // an occupied slot stays put when its time is not later than the new one
    assign le   = occupied && !(slot_reg.ev_time > ctl.item.ev_time);
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.ins)
        begin
            if (!le)
            begin
                slot_next = left_le ? ctl.item : left_data;
            end
        end
        else if (ctl.pop)
        begin
            slot_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// File: rtl/stable_sorted_event_queue.sv
// top level of the stable sorted event queue
// Holds up to QUEUE_DEPTH events in a chain of slots kept sorted by timestamp, events with
// equal times staying in arrival order. A request (insert or pop) is taken in any cycle in
// which start is high; busy never rises, so one request per clock is sustained. Each request
// gives exactly one result, shown with done in the cycle after the request, since
// every slot compares against the new timestamp and shifts in the same clock. The receiver
// cannot stall, so results must be captured when done is high. An insert into a full queue
// is dropped and reported with overflow; a pop on an empty queue returns popped_valid low.
module stable_sorted_event_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [sseq_pkg::TIME_W-1:0]   event_time,
    input  logic [sseq_pkg::PID_W-1:0]    process_id,
    input  logic [sseq_pkg::TRANS_W-1:0]  transition_code,
    output logic                          done,
    output logic                          popped_valid,
    output logic [sseq_pkg::TIME_W-1:0]   popped_time,
    output logic [sseq_pkg::PID_W-1:0]    popped_process,
    output logic [sseq_pkg::TRANS_W-1:0]  popped_transition,
    output logic                          overflow,
    output logic                          head_valid,
    output logic [sseq_pkg::TIME_W-1:0]   head_time,
    output logic [sseq_pkg::OCC_W-1:0]    occupancy
);
    import sseq_pkg::*;

    logic               accept;
    logic               is_pop;
    logic               full;
    logic               empty;
    cell_ctl_t          ctl;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    event_t             slot      [QUEUE_DEPTH];
    event_t             slot_next [QUEUE_DEPTH];
    logic               le        [QUEUE_DEPTH];

    logic               done_reg;
    logic               popped_valid_reg;
    event_t             popped_reg;
    logic               overflow_reg;
    logic               head_valid_reg;
    logic [TIME_W-1:0]  head_time_reg;
    logic [OCC_W-1:0]   occupancy_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_pop = (command == CMD_POP);
    assign full   = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctl.ins  = accept && !is_pop && !full;
        ctl.pop  = accept && is_pop && !empty;
        ctl.item = '{ev_time: event_time, pid: process_id, trans: transition_code};
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_le_w;
        event_t left_w;
        event_t right_w;

        if (i == 0)
        begin : g_first
            assign left_le_w = 1'b1;
            assign left_w    = ctl.item;
        end
        else
        begin : g_mid
            assign left_le_w = le[i-1];
            assign left_w    = slot[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_w = slot[i];
        end
        else
        begin : g_inner
            assign right_w = slot[i+1];
        end

        sseq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (COUNT_W'(i) < count_reg),
            .left_le    (left_le_w),
            .left_data  (left_w),
            .right_data (right_w),
            .le         (le[i]),
            .slot       (slot[i]),
            .slot_next  (slot_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_valid_reg <= ctl.pop;
            popped_reg       <= ctl.pop ? slot[0] : '0;
            overflow_reg     <= !is_pop && full;
            head_valid_reg   <= (count_next != '0);
            head_time_reg    <= (count_next != '0) ? slot_next[0].ev_time : '0;
            occupancy_reg    <= OCC_W'(count_next);
        end
    end

    assign done              = done_reg;
    assign popped_valid      = popped_valid_reg;
    assign popped_time       = popped_reg.ev_time;
    assign popped_process    = popped_reg.pid;
    assign popped_transition = popped_reg.trans;
    assign overflow          = overflow_reg;
    assign head_valid        = head_valid_reg;
    assign head_time         = head_time_reg;
    assign occupancy         = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("event count beyond depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= COUNT_W'(2) |-> !(slot[0].ev_time > slot[1].ev_time))
        else $error("head slots out of order");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_pop && full |=> done && overflow && count_reg == $past(count_reg))
        else $error("overflow insert changed the queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> popped_valid && count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("pop did not remove one event");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> head_valid == (count_reg != '0))
        else $error("head_valid disagrees with count");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the stable sorted event queue
`timescale 1ns / 1ps

module testbench;

    import sseq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 1225;
    localparam int CALM_TAIL    = 150;

    typedef struct packed {
        logic                popped_valid;
        logic [TIME_W-1:0]   popped_time;
        logic [PID_W-1:0]    popped_process;
        logic [TRANS_W-1:0]  popped_transition;
        logic                overflow;
        logic                head_valid;
        logic [TIME_W-1:0]   head_time;
        logic [OCC_W-1:0]    occupancy;
    } outcome_t;

    typedef struct {
        logic                cmd;
        logic [TIME_W-1:0]   ev_time;
        logic [PID_W-1:0]    pid;
        logic [TRANS_W-1:0]  trans;
        bit                  drain_first;
    } request_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                command = CMD_POP;
    logic [TIME_W-1:0]   event_time = '0;
    logic [PID_W-1:0]    process_id = '0;
    logic [TRANS_W-1:0]  transition_code = '0;
    logic                busy;
    logic                done;
    logic                popped_valid;
    logic [TIME_W-1:0]   popped_time;
    logic [PID_W-1:0]    popped_process;
    logic [TRANS_W-1:0]  popped_transition;
    logic                overflow;
    logic                head_valid;
    logic [TIME_W-1:0]   head_time;
    logic [OCC_W-1:0]    occupancy;

    request_t  request_backlog[$];
    outcome_t  expected_outcomes[$];
    event_t    sorted_events[QUEUE_DEPTH];
    int        stored_count = 0;
    int        idle_left = 0;
    int        mismatches = 0;
    int        cycles = 0;

    logic [TIME_W-1:0] directed_times [16] = '{
        32'hFFFF_FFFF, 32'h0, 32'h5, 32'h5, 32'h5, 32'h0, 32'hFFFF_FFFF, 32'h64,
        32'h5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h64, 32'h3, 32'hFFFF_FFFE, 32'h5, 32'h1
    };

    stable_sorted_event_queue u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .event_time        (event_time),
        .process_id        (process_id),
        .transition_code   (transition_code),
        .done              (done),
        .popped_valid      (popped_valid),
        .popped_time       (popped_time),
        .popped_process    (popped_process),
        .popped_transition (popped_transition),
        .overflow          (overflow),
        .head_valid        (head_valid),
        .head_time         (head_time),
        .occupancy         (occupancy)
    );

    always #2 clk = ~clk;

    // stable insertion after equal timestamps, pop from the head
    task automatic apply_queue_request(input logic cmd, input logic [TIME_W-1:0] t,
                                       input logic [PID_W-1:0] pid,
                                       input logic [TRANS_W-1:0] trans);
        outcome_t o;
        int       pos;
        o = '0;
        if (cmd == CMD_INSERT)
        begin
            if (stored_count >= QUEUE_DEPTH)
            begin
                o.overflow = 1'b1;
            end
            else
            begin
                pos = stored_count;
                while (pos > 0 && sorted_events[pos-1].ev_time > t)
                begin
                    sorted_events[pos] = sorted_events[pos-1];
                    pos--;
                end
                sorted_events[pos].ev_time = t;
                sorted_events[pos].pid     = pid;
                sorted_events[pos].trans   = trans;
                stored_count++;
            end
        end
        else if (stored_count > 0)
        begin
            o.popped_valid      = 1'b1;
            o.popped_time       = sorted_events[0].ev_time;
            o.popped_process    = sorted_events[0].pid;
            o.popped_transition = sorted_events[0].trans;
            for (pos = 1; pos < stored_count; pos++)
                sorted_events[pos-1] = sorted_events[pos];
            stored_count--;
        end
        o.head_valid = (stored_count > 0);
        o.head_time  = (stored_count > 0) ? sorted_events[0].ev_time : '0;
        o.occupancy  = stored_count[OCC_W-1:0];
        expected_outcomes.insert(expected_outcomes.size(), o);
    endtask

    function automatic void queue_request(input logic cmd, input logic [TIME_W-1:0] t,
                                          input logic [PID_W-1:0] pid,
                                          input logic [TRANS_W-1:0] trans,
                                          input bit drain_first);
        request_t r;
        r.cmd         = cmd;
        r.ev_time     = t;
        r.pid         = pid;
        r.trans       = trans;
        r.drain_first = drain_first;
        request_backlog.insert(request_backlog.size(), r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        request_t nxt;
        if (!rst_n)
        begin
            start           <= 1'b0;
            command         <= CMD_POP;
            event_time      <= '0;
            process_id      <= '0;
            transition_code <= '0;
            idle_left       <= 0;
        end
        else
        begin
            if (start && !busy)
                apply_queue_request(command, event_time, process_id, transition_code);
            if (!(start && busy))
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    start     <= 1'b0;
                end
                else if (request_backlog.size() == 0 ||
                         (request_backlog[0].drain_first && expected_outcomes.size() != 0))
                begin
                    start <= 1'b0;
                end
                else
                begin
                    nxt = request_backlog[0];
                    request_backlog.delete(0);
                    command         <= nxt.cmd;
                    event_time      <= nxt.ev_time;
                    process_id      <= nxt.pid;
                    transition_code <= nxt.trans;
                    start           <= 1'b1;
                    if (request_backlog.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
                        idle_left <= $urandom_range(1, 15);
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        outcome_t got;
        outcome_t want;
        if (rst_n && done)
        begin
            got.popped_valid      = popped_valid;
            got.popped_time       = popped_time;
            got.popped_process    = popped_process;
            got.popped_transition = popped_transition;
            got.overflow          = overflow;
            got.head_valid        = head_valid;
            got.head_time         = head_time;
            got.occupancy         = occupancy;
            if (expected_outcomes.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result at cycle %0d", cycles);
                mismatches++;
            end
            else
            begin
                want = expected_outcomes[0];
                expected_outcomes.delete(0);
                if (got !== want)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected pv=%0b pt=%h pp=%h ptr=%0d ovf=%0b",
                                 want.popped_valid, want.popped_time, want.popped_process,
                                 want.popped_transition, want.overflow);
                        $display("           hv=%0b ht=%h occ=%0d",
                                 want.head_valid, want.head_time, want.occupancy);
                        $display("  actual   pv=%0b pt=%h pp=%h ptr=%0d ovf=%0b",
                                 got.popped_valid, got.popped_time, got.popped_process,
                                 got.popped_transition, got.overflow);
                        $display("           hv=%0b ht=%h occ=%0d",
                                 got.head_valid, got.head_time, got.occupancy);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int          k;
        int          mode_left;
        int          insert_pct;
        logic        cmd;
        logic [TIME_W-1:0] t;
        logic [TRANS_W-1:0] trans;

        // pop on empty, fill to full, insert into full, partial drain
        queue_request(CMD_POP, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b0);
        for (k = 0; k < 16; k++)
            queue_request(CMD_INSERT, directed_times[k], (k == 0) ? 8'hFF : 8'(k * 17),
                          3'(k), 1'b0);
        queue_request(CMD_INSERT, 32'h2, 8'hAA, 3'd4, 1'b0);
        for (k = 0; k < 7; k++)
            queue_request(CMD_POP, $urandom, 8'($urandom), 3'($urandom), 1'b0);

        mode_left  = 0;
        insert_pct = 50;
        for (k = 0; k < RANDOM_COUNT; k++)
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            mode_left--;
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: t = $urandom_range(0, 15);
                5, 6:          t = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
                default:       t = $urandom;
            endcase
            trans = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            queue_request(cmd, t, 8'($urandom_range(0, 255)), trans,
                          (k == 0) || (k == RANDOM_COUNT / 2));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || start || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        mismatches = mismatches + expected_outcomes.size();
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
